// ===== design/cmrs_pkg.sv =====
package cmrs_pkg;

   localparam int FORM_COUNT  = 32;
   localparam int TREE_LEVELS = $clog2(FORM_COUNT);

   // combined cost/quality rank, lower is better, ordered cost ascending then quality descending
   localparam logic [2:0] RANK_C1_Q0 = 3'd0;
   localparam logic [2:0] RANK_C2_Q1 = 3'd1;
   localparam logic [2:0] RANK_C2_Q0 = 3'd2;
   localparam logic [2:0] RANK_C3_Q3 = 3'd3;
   localparam logic [2:0] RANK_C3_Q2 = 3'd4;
   localparam logic [2:0] RANK_C3_Q1 = 3'd5;
   localparam logic [2:0] RANK_C3_Q0 = 3'd6;
   localparam logic [2:0] RANK_NONE  = 3'd7;

   localparam logic [2:0] GROUP_PLAIN  = 3'd0;
   localparam logic [2:0] GROUP_UNIT   = 3'd1;
   localparam logic [2:0] GROUP_SCALED = 3'd2;
   localparam logic [2:0] GROUP_DOUBLE = 3'd3;
   localparam logic [2:0] GROUP_SHIFT  = 3'd4;

   typedef struct packed {
      logic [2:0]        group;
      logic signed [7:0] offset;
      logic              negate;
   } form_type;

   typedef struct packed {
      logic [2:0]        rank;
      logic [2:0]        algorithm;
      logic [4:0]        shift_amount;
      logic signed [7:0] offset;
      logic              negate;
      logic [6:0]        odd_factor;
   } cand_type;

   // every form in trial order; forms that can never score are left out
   localparam form_type FORM_TABLE [FORM_COUNT] = '{
      '{GROUP_PLAIN,   8'sd0, 1'b0}, '{GROUP_PLAIN,   8'sd0, 1'b1},
      '{GROUP_UNIT,   -8'sd1, 1'b0}, '{GROUP_UNIT,    8'sd1, 1'b0},
      '{GROUP_UNIT,    8'sd1, 1'b1},
      '{GROUP_SCALED, -8'sd9, 1'b0}, '{GROUP_SCALED, -8'sd5, 1'b0},
      '{GROUP_SCALED, -8'sd3, 1'b0}, '{GROUP_SCALED,  8'sd3, 1'b0},
      '{GROUP_SCALED,  8'sd3, 1'b1}, '{GROUP_SCALED,  8'sd5, 1'b0},
      '{GROUP_SCALED,  8'sd5, 1'b1}, '{GROUP_SCALED,  8'sd9, 1'b0},
      '{GROUP_SCALED,  8'sd9, 1'b1},
      '{GROUP_DOUBLE,  8'sd6, 1'b0}, '{GROUP_DOUBLE, 8'sd10, 1'b0},
      '{GROUP_DOUBLE, 8'sd12, 1'b0}, '{GROUP_DOUBLE, 8'sd18, 1'b0},
      '{GROUP_DOUBLE, 8'sd20, 1'b0}, '{GROUP_DOUBLE, 8'sd24, 1'b0},
      '{GROUP_DOUBLE, 8'sd36, 1'b0}, '{GROUP_DOUBLE, 8'sd40, 1'b0},
      '{GROUP_DOUBLE, 8'sd72, 1'b0},
      '{GROUP_SHIFT,  -8'sd8, 1'b0}, '{GROUP_SHIFT,  -8'sd4, 1'b0},
      '{GROUP_SHIFT,  -8'sd2, 1'b0}, '{GROUP_SHIFT,   8'sd2, 1'b0},
      '{GROUP_SHIFT,   8'sd2, 1'b1}, '{GROUP_SHIFT,   8'sd4, 1'b0},
      '{GROUP_SHIFT,   8'sd4, 1'b1}, '{GROUP_SHIFT,   8'sd8, 1'b0},
      '{GROUP_SHIFT,   8'sd8, 1'b1}
   };

   // trailing zero count of a nonzero word
   function automatic logic [4:0] tz_count(input logic [31:0] u);
      logic [4:0] n;
      n = 5'd31;
      for (int i = 31; i >= 0; i--) begin
         if (u[i]) begin
            n = 5'(i);
         end
      end
      return n;
   endfunction

   function automatic logic [2:0] form_rank(input logic [2:0] group, input logic neg,
                                            input logic has_shift, input logic fits,
                                            input logic [6:0] t);
      logic is_one;
      logic is_359;
      logic is_sq;
      logic [2:0] rank;
      is_one = fits && (t == 7'd1);
      is_359 = fits && (t == 7'd3 || t == 7'd5 || t == 7'd9);
      is_sq  = fits && (t == 7'd15 || t == 7'd25 || t == 7'd27 || t == 7'd45 || t == 7'd81);
      rank   = RANK_NONE;
      case (group)
         GROUP_PLAIN: begin
            if (is_one) begin
               rank = neg ? RANK_C2_Q0 : RANK_C1_Q0;
            end else if (is_359) begin
               if (neg) begin
                  rank = has_shift ? RANK_C3_Q0 : RANK_C2_Q0;
               end else begin
                  rank = has_shift ? RANK_C2_Q0 : RANK_C1_Q0;
               end
            end else if (!neg && is_sq) begin
               rank = has_shift ? RANK_C3_Q1 : RANK_C2_Q1;
            end
         end
         GROUP_UNIT: begin
            if (is_one) begin
               rank = RANK_C3_Q3;
            end else if (is_359) begin
               rank = RANK_C3_Q2;
            end
         end
         GROUP_SCALED: begin
            if (is_one) rank = RANK_C3_Q2;
         end
         GROUP_DOUBLE: begin
            if (is_one && !neg) rank = RANK_C3_Q1;
         end
         GROUP_SHIFT: begin
            if (is_one) rank = RANK_C3_Q0;
         end
         default: begin
            rank = RANK_NONE;
         end
      endcase
      return rank;
   endfunction

endpackage

// ===== design/const_multiply_recipe_search_core.sv =====
// shift/add recipe search for a 32-bit multiplier constant: every word on req_ is scored
// against all 32 candidate forms in parallel; an accepted word sits in the input register, is
// scored, and lands in the result register once the result stage is free, raising rsp_valid;
// one word per cycle is sustained while rsp_stall is low, the single combinational
// evaluation of all forms between the two registers setting that figure; with the result
// stalled the block still takes one more word into the input register and stalls req_ only
// when both registers hold a word; fields read zero when no recipe of cost three or less exists
module const_multiply_recipe_search_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [31:0]         req_multiplier,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_found,
   output logic [2:0]          rsp_algorithm,
   output logic [4:0]          rsp_shift_amount,
   output logic signed [7:0]   rsp_offset,
   output logic                rsp_negate,
   output logic [6:0]          rsp_odd_factor
);
   import cmrs_pkg::*;

   // input stage
   logic        in_valid_ff, in_valid_in;
   logic [31:0] mult_ff, mult_in;

   // result stage
   logic        out_valid_ff, out_valid_in;
   cand_type    res_ff, res_in;

   logic        out_free;
   logic        advance;
   logic        accept;

   // per-form scoring and the selection tree
   cand_type    cand [FORM_COUNT];
   cand_type    tree [TREE_LEVELS+1][FORM_COUNT];
   cand_type    best;

   // result stage takes a new word when empty or when its word leaves this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   // score every form against the registered multiplier
   always_comb begin
      for (int f = 0; f < FORM_COUNT; f++) begin
         logic [31:0] oext;
         logic [31:0] u;
         logic [31:0] t;
         logic [4:0]  n;
         oext = {{24{FORM_TABLE[f].offset[7]}}, FORM_TABLE[f].offset};
         // negated form subtracts the other way round, one adder per form
         u    = FORM_TABLE[f].negate ? (oext - mult_ff) : (mult_ff - oext);
         n    = tz_count(u);
         t    = u >> n;
         cand[f].rank         = (u == 32'd0) ? RANK_NONE :
                                form_rank(FORM_TABLE[f].group, FORM_TABLE[f].negate,
                                          n != 5'd0, t[31:7] == 25'd0, t[6:0]);
         cand[f].algorithm    = FORM_TABLE[f].group;
         cand[f].shift_amount = n;
         // reported offset carries the sign choice
         cand[f].offset       = FORM_TABLE[f].negate ? -FORM_TABLE[f].offset
                                                     : FORM_TABLE[f].offset;
         cand[f].negate       = FORM_TABLE[f].negate;
         cand[f].odd_factor   = t[6:0];
      end
   end

   // pairwise reduction; the left (earlier) form keeps ties
   always_comb begin
      tree = '{default: '{default: '0}};
      for (int f = 0; f < FORM_COUNT; f++) begin
         tree[0][f] = cand[f];
      end
      for (int lv = 0; lv < TREE_LEVELS; lv++) begin
         for (int i = 0; i < (FORM_COUNT >> (lv + 1)); i++) begin
            if (tree[lv][2*i+1].rank < tree[lv][2*i].rank) begin
               tree[lv+1][i] = tree[lv][2*i+1];
            end else begin
               tree[lv+1][i] = tree[lv][2*i];
            end
         end
      end
      best = tree[TREE_LEVELS][0];
   end

   // next values
   always_comb begin
      in_valid_in  = in_valid_ff;
      mult_in      = mult_ff;
      out_valid_in = out_valid_ff;
      res_in       = res_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
      if (accept) begin
         mult_in = req_multiplier;
      end
      if (out_free) begin
         out_valid_in = in_valid_ff;
      end
      if (advance) begin
         // every defined rank has cost three or less
         if (best.rank != RANK_NONE) begin
            res_in = best;
         end else begin
            res_in      = '0;
            res_in.rank = RANK_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mult_ff <= mult_in;
      res_ff  <= res_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_found        = res_ff.rank != RANK_NONE;
   assign rsp_algorithm    = res_ff.algorithm;
   assign rsp_shift_amount = res_ff.shift_amount;
   assign rsp_offset       = res_ff.offset;
   assign rsp_negate       = res_ff.negate;
   assign rsp_odd_factor   = res_ff.odd_factor;

`ifndef SYNTHESIS
   // a not-found word carries all-zero fields
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_found |-> rsp_algorithm == 3'd0 && rsp_shift_amount == 5'd0 &&
         rsp_offset == 8'sd0 && !rsp_negate && rsp_odd_factor == 7'd0)
      else $error("not-found word with nonzero fields");

   // a recipe always ends in an odd factor
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_found |-> rsp_odd_factor[0])
      else $error("recipe with even odd factor");

   // the negated form only ever reports a non-positive offset
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_found && rsp_negate |-> !(rsp_offset > 8'sd0))
      else $error("negated recipe with positive offset");

   // an accepted word lands in the input stage
   assert property (@(posedge clock) disable iff (reset)
      accept |=> in_valid_ff)
      else $error("accepted word lost");
`endif

endmodule
